// ===== rtl/mi3_pkg.sv =====
// shared widths, index tables and helpers for the 3x3 matrix inverse
package mi3_pkg;

  localparam int FRAC_BITS_DEF = 16;
  // quotient bits below the overflow bit, plus one overflow bit
  localparam int QB     = 33;
  localparam int Q_W    = QB + 1;
  localparam int ENT_W  = 32;
  localparam int PROD_W = 64;
  localparam int COF_W  = 65;
  localparam int TERM_W = 97;
  localparam int DET_W  = 99;
  // register stages ahead of the divider
  localparam int PRE_ST = 7;

  localparam logic [ENT_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [ENT_W-1:0] NEG_MIN = 32'h8000_0000;

  typedef logic signed [ENT_W-1:0]  ent_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [DET_W-1:0]  det_t;

  // cofactor k = m[CA]*m[CB] - m[CC]*m[CD], row-major entry numbering
  localparam int CA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int CB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int CC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int CD [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  // cofactors paired with the first row in the determinant
  localparam int DI [3] = '{0, 3, 6};

  function automatic int div_width(input int nw, input int dw, input int qw);
    return (nw > dw + qw) ? nw : dw + qw;
  endfunction

endpackage

// ===== rtl/matrix_inverse_3x3_top.sv =====
// top level of the pipelined 3x3 fixed-point matrix inverse
//
// A request carries nine signed Q16.16 entries (m00..m22) and is taken at a
// rising edge where start is high and busy is low; busy is only high during
// reset, so a new matrix can enter on every clock. Each request gives one
// result: done pulses for one cycle with inv_00..inv_22, singular and
// saturated; the receiver cannot hold results off, so they must be captured
// in that cycle. The pipeline is seven stages of products, cofactors and
// determinant, then a 34-stage divider that produces one quotient bit per
// stage for each of the nine entries. The inverse is the adjugate over the
// exact determinant, rounded toward zero. A zero determinant gives all-zero
// entries with singular set; entries beyond the 32-bit range clip and set
// saturated.
module matrix_inverse_3x3_top #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  mi3_pkg::ent_t m00,
  input  mi3_pkg::ent_t m01,
  input  mi3_pkg::ent_t m02,
  input  mi3_pkg::ent_t m10,
  input  mi3_pkg::ent_t m11,
  input  mi3_pkg::ent_t m12,
  input  mi3_pkg::ent_t m20,
  input  mi3_pkg::ent_t m21,
  input  mi3_pkg::ent_t m22,
  output logic          done,
  output mi3_pkg::ent_t inv_00,
  output mi3_pkg::ent_t inv_01,
  output mi3_pkg::ent_t inv_02,
  output mi3_pkg::ent_t inv_10,
  output mi3_pkg::ent_t inv_11,
  output mi3_pkg::ent_t inv_12,
  output mi3_pkg::ent_t inv_20,
  output mi3_pkg::ent_t inv_21,
  output mi3_pkg::ent_t inv_22,
  output logic          singular,
  output logic          saturated
);
  import mi3_pkg::*;

  // numerator is the cofactor magnitude scaled by 2^(2F)
  localparam int NUM_W = COF_W + 2 * FRAC_BITS;
  localparam int VP_W  = PRE_ST + Q_W;
  localparam int LAT   = PRE_ST + Q_W + 1;

  logic acc;

  // valid bits, one per stage
  logic [VP_W-1:0] vp;

  // stage 1: captured entries
  ent_t  m1 [9];
  // stage 2: the eighteen 2x2 products, first row carried
  prod_t pr2 [18];
  ent_t  mr2 [3];
  // stage 3: cofactors
  cof_t  cof3 [9];
  ent_t  mr3 [3];
  // stage 4: split products of the determinant
  logic signed [COF_W-1:0] plo4 [3];
  logic signed [COF_W-1:0] phi4 [3];
  cof_t  cof4 [9];
  // stage 5: the three determinant terms
  term_t term5 [3];
  cof_t  cof5 [9];
  // stage 6: determinant
  det_t  det6;
  cof_t  cof6 [9];
  // stage 7: magnitudes and result signs
  logic [DET_W-1:0] dabs7;
  logic [COF_W-1:0] cabs7 [9];
  logic [8:0]       neg7;
  logic             sing7;

  // sideband travelling beside the divider
  logic [8:0] sn [Q_W];
  logic       ss [Q_W];

  logic [Q_W-1:0]   quo [9];
  logic [ENT_W-1:0] val [9];
  logic [8:0]       clip;
  ent_t             inv_r [9];

  // no back-pressure path: only reset holds requests off
  assign busy = rst;
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp   <= '0;
      done <= 1'b0;
    end else begin
      vp   <= {vp[VP_W-2:0], acc};
      done <= vp[VP_W-1];
    end
  end

  always_ff @(posedge clk) begin
    m1[0] <= m00; m1[1] <= m01; m1[2] <= m02;
    m1[3] <= m10; m1[4] <= m11; m1[5] <= m12;
    m1[6] <= m20; m1[7] <= m21; m1[8] <= m22;

    for (int k = 0; k < 9; k++) begin
      pr2[2*k]   <= m1[CA[k]] * m1[CB[k]];
      pr2[2*k+1] <= m1[CC[k]] * m1[CD[k]];
    end
    for (int j = 0; j < 3; j++) begin
      mr2[j] <= m1[j];
    end

    for (int k = 0; k < 9; k++) begin
      cof3[k] <= COF_W'(pr2[2*k]) - COF_W'(pr2[2*k+1]);
    end
    mr3 <= mr2;

    // 32 x 65 split into low unsigned and high signed halves
    for (int j = 0; j < 3; j++) begin
      plo4[j] <= mr3[j] * $signed({1'b0, cof3[DI[j]][31:0]});
      phi4[j] <= mr3[j] * $signed(cof3[DI[j]][COF_W-1:32]);
    end
    cof4 <= cof3;

    for (int j = 0; j < 3; j++) begin
      term5[j] <= (TERM_W'(phi4[j]) <<< 32) + TERM_W'(plo4[j]);
    end
    cof5 <= cof4;

    det6 <= DET_W'(term5[0]) + DET_W'(term5[1]) + DET_W'(term5[2]);
    cof6 <= cof5;

    dabs7 <= det6[DET_W-1] ? DET_W'(-det6) : DET_W'(det6);
    sing7 <= (det6 == '0);
    for (int k = 0; k < 9; k++) begin
      cabs7[k] <= cof6[k][COF_W-1] ? COF_W'(-cof6[k]) : COF_W'(cof6[k]);
      neg7[k]  <= cof6[k][COF_W-1] ^ det6[DET_W-1];
    end

    sn[0] <= neg7;
    ss[0] <= sing7;
    for (int s = 1; s < Q_W; s++) begin
      sn[s] <= sn[s-1];
      ss[s] <= ss[s-1];
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_div
    mi3_div #(
      .NUM_W (NUM_W),
      .DEN_W (DET_W),
      .QW    (Q_W)
    ) u_div (
      .clk (clk),
      .num ({cabs7[k], {(2 * FRAC_BITS){1'b0}}}),
      .den (dabs7),
      .quo (quo[k])
    );
  end

  // apply sign and clip to the 32-bit range
  always_comb begin
    logic [Q_W-1:0] nq;
    for (int k = 0; k < 9; k++) begin
      nq = ~quo[k] + Q_W'(1);
      if (sn[Q_W-1][k]) begin
        clip[k] = (quo[k] > Q_W'(NEG_MIN));
        val[k]  = clip[k] ? NEG_MIN : nq[ENT_W-1:0];
      end else begin
        clip[k] = (quo[k] > Q_W'(POS_MAX));
        val[k]  = clip[k] ? POS_MAX : quo[k][ENT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      inv_r[k] <= ss[Q_W-1] ? '0 : ent_t'(val[k]);
    end
    singular  <= ss[Q_W-1];
    saturated <= !ss[Q_W-1] && (|clip);
  end

  assign inv_00 = inv_r[0];
  assign inv_01 = inv_r[1];
  assign inv_02 = inv_r[2];
  assign inv_10 = inv_r[3];
  assign inv_11 = inv_r[4];
  assign inv_12 = inv_r[5];
  assign inv_20 = inv_r[6];
  assign inv_21 = inv_r[7];
  assign inv_22 = inv_r[8];

  // every request comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    acc |-> ##LAT done)
    else $error("request did not produce a result on time");

  // no result without a request
  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc, LAT))
    else $error("result without a matching request");

  // singular results are all zero and never saturated
  a_singular: assert property (@(posedge clk) disable iff (rst)
    (done && singular) |-> (!saturated && inv_00 == 0 && inv_01 == 0 &&
      inv_02 == 0 && inv_10 == 0 && inv_11 == 0 && inv_12 == 0 &&
      inv_20 == 0 && inv_21 == 0 && inv_22 == 0))
    else $error("singular result not cleared");

endmodule

// ===== rtl/mi3_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module mi3_div #(
  parameter int NUM_W = 97,
  parameter int DEN_W = 99,
  parameter int QW    = 34
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QW-1:0]    quo
);
  import mi3_pkg::*;

  localparam int CW = div_width(NUM_W, DEN_W, QW);

  logic [CW-1:0]    rem [QW];
  logic [DEN_W-1:0] dsr [QW];
  logic [QW-1:0]    qp  [QW];

  logic [CW-1:0]    rin [QW];
  logic [DEN_W-1:0] din [QW];
  logic [QW-1:0]    qin [QW];
  logic [CW-1:0]    rnx [QW];
  logic [QW-1:0]    qnx [QW];

  always_comb begin
    logic [CW-1:0] dsh;
    logic [CW:0]   diff;
    for (int s = 0; s < QW; s++) begin
      rin[s] = (s == 0) ? CW'(num) : rem[(s == 0) ? 0 : s - 1];
      din[s] = (s == 0) ? den : dsr[(s == 0) ? 0 : s - 1];
      qin[s] = (s == 0) ? '0 : qp[(s == 0) ? 0 : s - 1];
      dsh  = CW'(din[s]) << (QW - 1 - s);
      diff = {1'b0, rin[s]} - {1'b0, dsh};
      if (!diff[CW]) begin
        rnx[s] = diff[CW-1:0];
        qnx[s] = qin[s] | (QW'(1) << (QW - 1 - s));
      end else begin
        rnx[s] = rin[s];
        qnx[s] = qin[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QW; s++) begin
      rem[s] <= rnx[s];
      dsr[s] <= din[s];
      qp[s]  <= qnx[s];
    end
  end

  assign quo = qp[QW-1];

endmodule
